[hw/rtl/stream_find_replace_macros.svh]
// assertion macros used by the port level checker file
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sfr_pkg.sv]
// shared types, constants and helpers of the stream find and replace block
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int PATTERN_MAX     = 16;
  localparam int REPLACEMENT_MAX = 16;
  localparam int WIN_DEPTH       = 16;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 5;
  localparam int DATA_W          = 64;
  localparam int IDX_W           = 3;

  // effective length limits
  localparam logic [LEN_W-1:0] PLEN_LIM =
    LEN_W'((PATTERN_MAX < WIN_DEPTH) ? PATTERN_MAX : WIN_DEPTH);
  localparam logic [LEN_W-1:0] RLEN_LIM =
    LEN_W'((REPLACEMENT_MAX < WIN_DEPTH) ? REPLACEMENT_MAX : WIN_DEPTH);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_REPLACEMENT_LENGTH = 3'd1,
    REG_PATTERN_LOW        = 3'd2,
    REG_PATTERN_HIGH       = 3'd3,
    REG_REPLACEMENT_LOW    = 3'd4,
    REG_REPLACEMENT_HIGH   = 3'd5
  } cfg_reg_e;

  typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] byte_vec_t;

  // group of results produced by one item
  typedef struct packed {
    byte_vec_t        bytes;
    logic [LEN_W-1:0] len;
    logic             none;
    logic             last;
  } burst_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

[hw/rtl/stream_find_replace.sv]
// Streaming substring find and replace, top level.
// An input transfer reaches the earliest transfer of its first result through
// the input register, then the result burst register, which can stall it.
// Throughput: one input per cycle while each input yields at most one result
// and the output is ready; k results hold the burst register until all are sent.
// Reset clears configuration, the window fill count and all valid state.
`timescale 1ns / 1ps

module stream_find_replace import sfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_none_o,
  output logic              out_last_o
);

  logic [LEN_W-1:0]  plen_q, rlen_q;
  logic [DATA_W-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;

  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;

  logic              can_load;
  logic              advance;
  logic              clear;
  burst_t            burst;
  byte_vec_t         pattern, replacement;

  assign advance    = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || advance;
  assign clear      = cfg_we_i && (cfg_index_i == REG_PATTERN_LENGTH);
  assign pattern     = {pat_hi_q, pat_lo_q};
  assign replacement = {rep_hi_q, rep_lo_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= '0;
      rlen_q   <= '0;
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      rep_lo_q <= '0;
      rep_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_LENGTH:     plen_q   <= cfg_data_i[LEN_W-1:0];
        REG_REPLACEMENT_LENGTH: rlen_q   <= cfg_data_i[LEN_W-1:0];
        REG_PATTERN_LOW:        pat_lo_q <= cfg_data_i;
        REG_PATTERN_HIGH:       pat_hi_q <= cfg_data_i;
        REG_REPLACEMENT_LOW:    rep_lo_q <= cfg_data_i;
        REG_REPLACEMENT_HIGH:   rep_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  sfr_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .clear_i       (clear),
    .byte_i        (in_byte_q),
    .last_i        (in_last_q),
    .plen_i        (clamp_len(plen_q, PLEN_LIM)),
    .rlen_i        (clamp_len(rlen_q, RLEN_LIM)),
    .pattern_i     (pattern),
    .replacement_i (replacement),
    .burst_o       (burst)
  );

  sfr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (burst.len != '0)),
    .burst_i     (burst),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_none_o  (out_none_o),
    .out_last_o  (out_last_o)
  );

endmodule

[hw/rtl/sfr_window.sv]
// match window, pattern compare and result burst builder
`timescale 1ns / 1ps

module sfr_window import sfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             clear_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic             last_i,
  input  logic [LEN_W-1:0] plen_i,
  input  logic [LEN_W-1:0] rlen_i,
  input  byte_vec_t        pattern_i,
  input  byte_vec_t        replacement_i,
  output burst_t           burst_o
);

  byte_vec_t        win_q, win_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;

  byte_vec_t        nw;
  byte_vec_t        shifted;
  logic             full;
  logic             hit;
  logic [LEN_W-1:0] k;

  // window with the new byte placed after the held ones
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      nw[i] = (LEN_W'(i) == cnt_q) ? byte_i : win_q[i];
    end
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      shifted[i] = nw[i+1];
    end
    shifted[WIN_DEPTH-1] = nw[WIN_DEPTH-1];
  end

  // full window compare against the pattern
  always_comb begin
    full = (plen_i != '0) && (cnt_q == plen_i - LEN_W'(1));
    hit  = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((LEN_W'(i) < plen_i) && (nw[i] != pattern_i[i])) begin
        hit = 1'b0;
      end
    end
  end

  // next window state and result burst
  always_comb begin
    win_d         = nw;
    cnt_d         = cnt_q;
    k             = '0;
    burst_o.bytes = nw;
    burst_o.none  = 1'b0;
    burst_o.last  = last_i;
    if (plen_i == '0) begin
      burst_o.bytes    = '0;
      burst_o.bytes[0] = byte_i;
      k                = LEN_W'(1);
    end else if (full && hit) begin
      burst_o.bytes = replacement_i;
      k             = rlen_i;
      cnt_d         = '0;
    end else if (full) begin
      win_d = shifted;
      k     = last_i ? plen_i : LEN_W'(1);
      cnt_d = last_i ? '0 : cnt_q;
    end else begin
      k     = last_i ? (cnt_q + LEN_W'(1)) : '0;
      cnt_d = last_i ? '0 : (cnt_q + LEN_W'(1));
    end
    // end marker when the last item leaves nothing to send
    if (last_i && (k == '0)) begin
      burst_o.bytes = '0;
      burst_o.none  = 1'b1;
      k             = LEN_W'(1);
    end
    burst_o.len = k;
  end

  // held bytes
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      win_q <= win_d;
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (clear_i) begin
      cnt_q <= '0;
    end else if (advance_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/sfr_emit.sv]
// result burst register that sends one result per transfer
`timescale 1ns / 1ps

module sfr_emit import sfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  burst_t            burst_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_none_o,
  output logic              out_last_o
);

  byte_vec_t        buf_q, buf_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             none_q, none_d;
  logic             last_q, last_d;
  logic             pop;

  assign out_valid_o = (rem_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (rem_q == '0) || ((rem_q == LEN_W'(1)) && out_ready_i);
  assign out_byte_o  = buf_q[0];
  assign out_none_o  = none_q;
  assign out_last_o  = last_q && (rem_q == LEN_W'(1));

  // shift on transfer, reload with a new burst
  always_comb begin
    buf_d  = buf_q;
    rem_d  = rem_q;
    none_d = none_q;
    last_d = last_q;
    if (pop) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      rem_d = rem_q - LEN_W'(1);
    end
    if (load_i) begin
      buf_d  = burst_i.bytes;
      rem_d  = burst_i.len;
      none_d = burst_i.none;
      last_d = burst_i.last;
    end
  end

  // burst payload
  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    none_q <= none_d;
    last_q <= last_d;
  end

  // remaining results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

[hw/rtl/sfr_checker.sv]
// port level checks of the stream find and replace block
`timescale 1ns / 1ps
`include "stream_find_replace_macros.svh"

module sfr_checker import sfr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] out_byte_o,
  input logic              out_none_o,
  input logic              out_last_o
);

  // end marker carries no byte and closes the text
  `SFR_ASSERT(a_marker_form, !(out_valid_o && out_none_o) || (out_last_o && (out_byte_o == '0)), "end marker malformed")

  // with no result pending the input side never stalls
  `SFR_ASSERT(a_idle_ready, out_valid_o || in_ready_o, "input stalled while output idle")

  // a stalled result holds
  `SFR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(out_none_o) && $stable(out_last_o), "stalled result changed")

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
